// ===== rtl/mru_pkg.sv =====
// Package for the MRU recency list: word field widths, op codes, defaults
// and the struct handed from cell to cell along the chain. No dependencies.
package mru_pkg;

  localparam int DEPTH_DEF    = 8;
  localparam int ID_WIDTH_DEF = 16;

  // Fixed widths of the channel fields
  localparam int ID_W  = 16;
  localparam int POS_W = 3;
  localparam int CNT_W = 4;

  localparam logic [CNT_W-1:0] CAP_RESET = 4'd8;

  localparam logic OP_VISIT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Match status rippling from the newest cell towards the oldest
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } mru_chain_t;

endpackage

// ===== rtl/mru_ifs.sv =====
// Channel interfaces for the MRU recency list: request, response and
// capacity write. Depends on mru_pkg for field widths.
interface mru_req_if import mru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [ID_W-1:0]  visited_id;
  logic [POS_W-1:0] read_position;

  modport source (output valid, op, visited_id, read_position, input ready);
  modport sink   (input valid, op, visited_id, read_position, output ready);
endinterface

interface mru_rsp_if import mru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] list_length;
  logic             hit;
  logic [POS_W-1:0] hit_position;
  logic [CNT_W-1:0] evicted_count;
  logic             entry_valid;
  logic [ID_W-1:0]  entry_value;

  modport source (output valid, list_length, hit, hit_position, evicted_count,
                  entry_valid, entry_value, input ready);
  modport sink   (input valid, list_length, hit, hit_position, evicted_count,
                  entry_valid, entry_value, output ready);
endinterface

interface mru_cfg_if import mru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/mru_recency_list.sv =====
// Top level of the MRU recency list: a chain of mru_cell slots, length and
// capacity registers and the response register. Depends on mru_pkg, mru_ifs, mru_cell.
//
// Most-recently-used list of up to DEPTH identifiers, newest in slot 0. One
// request word is taken per clock and its response appears in the next cycle
// from a single output register; a request is taken while that register is
// empty or being drained. Every slot compares in parallel, and the first-match
// flag ripples down the cell chain, so the chain length (DEPTH) sets the clock.
// A visit moves the identifier to the front and trims to the capacity; a
// capacity write takes effect at the next visit.
module mru_recency_list import mru_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  mru_req_if.sink    req,
  mru_rsp_if.source  rsp,
  mru_cfg_if.sink    cfg
);

  localparam int LW   = $clog2(DEPTH + 2);
  localparam int SW   = (LW > CNT_W) ? LW : CNT_W;
  localparam int RD_N = (DEPTH < 8) ? DEPTH : 8;

  logic [LW-1:0]       length;
  logic [LW-1:0]       length_next;
  logic [CNT_W-1:0]    capacity;
  logic                take;
  logic                visit;
  logic [ID_WIDTH-1:0] id;

  logic [ID_WIDTH-1:0] cell_entry [DEPTH];
  logic [ID_WIDTH-1:0] cell_d     [DEPTH];
  mru_chain_t          chain      [DEPTH+1];

  logic             hit;
  logic [SW-1:0]    len_s;
  logic [SW-1:0]    cap_s;
  logic [SW-1:0]    newlen;
  logic [SW-1:0]    evicted;
  logic             rd_valid;
  logic [ID_W-1:0]  rd_value;

  assign take  = req.valid && req.ready;
  assign visit = take && (req.op == OP_VISIT);
  assign id    = ID_WIDTH'(req.visited_id);
  assign chain[0] = '{found: 1'b0, pos: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_d[i] = id;
    end else begin : g_body
      assign cell_d[i] = cell_entry[i-1];
    end
    mru_cell #(.IDX(i), .ID_WIDTH(ID_WIDTH), .LW(LW)) u_cell (
      .clk       (clk),
      .visit     (visit),
      .id        (id),
      .length    (length),
      .d_in      (cell_d[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .entry     (cell_entry[i])
    );
  end

  assign hit = chain[DEPTH].found;

  // Length after the visit, trimmed to the capacity saturated at DEPTH
  always_comb begin
    len_s   = SW'(length);
    cap_s   = (SW'(capacity) > SW'(DEPTH)) ? SW'(DEPTH) : SW'(capacity);
    newlen  = len_s - SW'(hit) + SW'(1);
    evicted = '0;
    if (cap_s == '0) begin
      evicted = len_s - SW'(hit);
      newlen  = '0;
    end else if (newlen > cap_s) begin
      evicted = newlen - cap_s;
      newlen  = cap_s;
    end
    length_next = LW'(newlen);
  end

  always_comb begin
    rd_valid = 1'b0;
    rd_value = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (req.read_position == POS_W'(i) && SW'(i) < len_s) begin
        rd_valid = 1'b1;
        rd_value = ID_W'(cell_entry[i]);
      end
    end
  end

  assign req.ready = !rsp.valid || rsp.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      if (visit) begin
        length <= length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Hold the response word until taken
  always_ff @(posedge clk) begin
    if (take) begin
      if (req.op == OP_VISIT) begin
        rsp.list_length   <= newlen[CNT_W-1:0];
        rsp.hit           <= hit;
        rsp.hit_position  <= chain[DEPTH].pos;
        rsp.evicted_count <= evicted[CNT_W-1:0];
        rsp.entry_valid   <= 1'b0;
        rsp.entry_value   <= '0;
      end else begin
        rsp.list_length   <= len_s[CNT_W-1:0];
        rsp.hit           <= 1'b0;
        rsp.hit_position  <= '0;
        rsp.evicted_count <= '0;
        rsp.entry_valid   <= rd_valid;
        rsp.entry_value   <= rd_value;
      end
    end
  end

endmodule

// ===== rtl/mru_cell.sv =====
// One slot of the MRU list: holds an identifier, compares it with the visited
// one and takes its newer neighbour's value on a shift. Depends on mru_pkg.
module mru_cell import mru_pkg::*; #(
  parameter int IDX      = 0,
  parameter int ID_WIDTH = ID_WIDTH_DEF,
  parameter int LW       = 4
) (
  input  logic                clk,
  input  logic                visit,
  input  logic [ID_WIDTH-1:0] id,
  input  logic [LW-1:0]       length,
  input  logic [ID_WIDTH-1:0] d_in,
  input  mru_chain_t          chain_in,
  output mru_chain_t          chain_out,
  output logic [ID_WIDTH-1:0] entry
);

  localparam logic [LW:0] IDX_L = (LW+1)'(IDX);

  logic in_list;
  logic match;
  logic load;

  assign in_list = IDX_L < {1'b0, length};
  assign match   = in_list && (entry == id);

  // Shift up to and including the first match, or over the whole list on a miss
  assign load = visit && !chain_in.found && (IDX_L <= {1'b0, length});

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && match) begin
      chain_out.found = 1'b1;
      chain_out.pos   = POS_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= d_in;
    end
  end

endmodule
